### design/lapsel_pkg.sv
// Package for the largest aligned page select block: constants, word types and
// the state word carried along the cell chain. No dependencies.
package lapsel_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int MAX_ORDER  = 30;
   localparam int ORDER_W    = 5;
   localparam int NUM_CELLS  = MAX_ORDER - PAGE_SHIFT;

   localparam logic [ADDR_W-1:0] PAGE_LOW = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;

   typedef enum logic [1:0] {
      CSR_REGION_START    = 2'd0,
      CSR_REGION_SIZE     = 2'd1,
      CSR_REGION_WRITABLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] hint_addr;
      logic              want_write;
      logic [ADDR_W-1:0] window_low;
      logic [ADDR_W-1:0] window_high;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [ADDR_W-1:0]  page_base;
      logic [ORDER_W-1:0] page_order;
      logic               write_granted;
      logic [ADDR_W-1:0]  hint_page;
   } rsp_type;

   // Per-word state handed from cell to cell.
   typedef struct packed {
      logic               status;     // offset out of range
      logic               alive;      // order may still grow
      logic               wr;         // write granted
      logic [ORDER_W-1:0] order;
      logic [ADDR_W-1:0]  adr;        // region_start + page offset
      logic [ADDR_W-1:0]  hot;        // page-truncated hot spot
      logic [ADDR_W-1:0]  win_low;    // page-truncated window low
      logic [ADDR_W-1:0]  win_last;   // rounded window high minus one
      logic [ADDR_W:0]    region_end; // region_start + region_size, no wrap
   } cell_type;

endpackage

### design/largest_aligned_page_select_top.sv
// Top level of the largest aligned page select block: region registers, entry
// stage, order cell chain and result register. Depends on lapsel_pkg,
// lapsel_front and lapsel_cell.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req  (lapsel_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready   rsp  (lapsel_pkg::rsp_type)
//   csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One word is in flight at a time. A word accepted on req_ passes through one
// entry stage, 18 order cells (one per possible doubling from order 12 to
// order 30) and the result register before it leaves as a result word.
// The next request word is taken once the result word has been taken on rsp_.
// Reset is synchronous and active high; it clears the region registers and all
// valid flags, and both ready outputs stay low while it is held.
// A stall on rsp_ holds the result register and keeps req_ready low.
module largest_aligned_page_select_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lapsel_pkg::req_type           req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lapsel_pkg::rsp_type           rsp,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [lapsel_pkg::ADDR_W-1:0] csr_data
);

   localparam int AW = lapsel_pkg::ADDR_W;
   localparam int NC = lapsel_pkg::NUM_CELLS;

   // Region configuration.
   logic [AW-1:0] region_start_ff;
   logic [AW-1:0] region_size_ff;
   logic          region_writable_ff;

   // Flow control: busy from request acceptance until the result is taken.
   logic busy_ff;
   logic busy_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   lapsel_pkg::rsp_type rsp_ff;
   lapsel_pkg::rsp_type rsp_in;

   logic req_fire;
   logic rsp_fire;

   // Chain taps: index 0 is the entry stage output, index NC the last cell.
   logic                 chain_valid [0:NC];
   lapsel_pkg::cell_type chain_word  [0:NC];

   lapsel_pkg::cell_type last_word;
   logic [AW-1:0]        base_mask;

   assign req_ready = !busy_ff && !reset;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = !reset;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff    <= '0;
         region_size_ff     <= '0;
         region_writable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lapsel_pkg::CSR_REGION_START:    region_start_ff    <= csr_data;
            lapsel_pkg::CSR_REGION_SIZE:     region_size_ff     <= csr_data;
            lapsel_pkg::CSR_REGION_WRITABLE: region_writable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   lapsel_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_fire),
      .req             (req),
      .region_start    (region_start_ff),
      .region_size     (region_size_ff),
      .region_writable (region_writable_ff),
      .out_valid       (chain_valid[0]),
      .out_word        (chain_word[0])
   );

   // Each cell tries one more doubling of the block.
   for (genvar k = 0; k < NC; k++) begin : g_cell
      lapsel_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .region_start (region_start_ff),
         .in_valid     (chain_valid[k]),
         .in_word      (chain_word[k]),
         .out_valid    (chain_valid[k+1]),
         .out_word     (chain_word[k+1])
      );
   end

   // Build the result word from the end of the chain. An out-of-range
   // offset returns status set and all other fields zero.
   always_comb begin
      last_word = chain_word[NC];
      base_mask = AW'(((AW + 1)'(1) << last_word.order) - (AW + 1)'(1));
      if (last_word.status) begin
         rsp_in = '0;
         rsp_in.status = 1'b1;
      end else begin
         rsp_in.status        = 1'b0;
         rsp_in.page_base     = last_word.adr & ~base_mask;
         rsp_in.page_order    = last_word.order;
         rsp_in.write_granted = last_word.wr;
         rsp_in.hint_page     = last_word.hot;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (rsp_fire) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (chain_valid[NC]) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (chain_valid[NC]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   // A result is only ever pending while the block counts itself busy.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result pending while not busy");

   // An accepted request enters the entry stage on the next cycle.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> chain_valid[0])
      else $error("accepted request did not enter the chain");

   // At most one word is on chain taps 0, NC/2, NC and the result register.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $countones({chain_valid[0], chain_valid[NC], chain_valid[NC/2],
                  rsp_valid_ff}) <= 1)
      else $error("more than one word in flight");

   // A successful result has an order within the allowed range.
   a_order_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.status) |->
      (rsp_ff.page_order >= lapsel_pkg::ORDER_W'(lapsel_pkg::PAGE_SHIFT)
       && rsp_ff.page_order <= lapsel_pkg::ORDER_W'(lapsel_pkg::MAX_ORDER)))
      else $error("result order out of range");
`endif

endmodule

### design/lapsel_front.sv
// Entry stage: truncates and rounds the request fields and forms the region
// address and end. Depends on lapsel_pkg.
module lapsel_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  lapsel_pkg::req_type             req,
   input  logic [lapsel_pkg::ADDR_W-1:0]   region_start,
   input  logic [lapsel_pkg::ADDR_W-1:0]   region_size,
   input  logic                            region_writable,
   output logic                            out_valid,
   output lapsel_pkg::cell_type            out_word
);

   logic                 valid_ff;
   lapsel_pkg::cell_type word_ff;
   lapsel_pkg::cell_type word_in;
   logic [lapsel_pkg::ADDR_W-1:0] offs;
   logic [lapsel_pkg::ADDR_W-1:0] hi;

   always_comb begin
      offs             = req.offset & ~lapsel_pkg::PAGE_LOW;
      hi               = (req.window_high + lapsel_pkg::PAGE_LOW) & ~lapsel_pkg::PAGE_LOW;
      word_in.status   = (offs >= region_size);
      word_in.alive    = (offs < region_size);
      word_in.wr       = req.want_write & region_writable;
      word_in.order    = lapsel_pkg::ORDER_W'(lapsel_pkg::PAGE_SHIFT);
      word_in.adr      = region_start + offs;
      word_in.hot      = req.hint_addr & ~lapsel_pkg::PAGE_LOW;
      word_in.win_low  = req.window_low & ~lapsel_pkg::PAGE_LOW;
      word_in.win_last = hi - lapsel_pkg::ADDR_W'(1);
      word_in.region_end = {1'b0, region_start} + {1'b0, region_size};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### design/lapsel_cell.sv
// One cell of the order chain: tests whether the block can double once more
// and hands the word on. Depends on lapsel_pkg.
module lapsel_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lapsel_pkg::ADDR_W-1:0]   region_start,
   input  logic                            in_valid,
   input  lapsel_pkg::cell_type            in_word,
   output logic                            out_valid,
   output lapsel_pkg::cell_type            out_word
);

   localparam int AW = lapsel_pkg::ADDR_W;

   logic                 valid_ff;
   lapsel_pkg::cell_type word_ff;
   lapsel_pkg::cell_type word_in;
   logic [lapsel_pkg::ORDER_W:0] n;
   logic [AW-1:0] low_mask;
   logic [AW-1:0] mb;
   logic [AW-1:0] hb;
   logic [AW:0]   mb_end;
   logic [AW:0]   hb_last;
   logic          grow;

   always_comb begin
      n        = {1'b0, in_word.order} + (lapsel_pkg::ORDER_W + 1)'(1);
      low_mask = AW'(((AW + 1)'(1) << n) - (AW + 1)'(1));
      mb       = in_word.adr & ~low_mask;
      hb       = in_word.hot & ~low_mask;
      mb_end   = {1'b0, mb} + {1'b0, low_mask} + (AW + 1)'(1);
      hb_last  = {1'b0, hb} + {1'b0, low_mask};
      grow     = in_word.alive
                 && (mb >= region_start)
                 && (mb_end <= in_word.region_end)
                 && (hb >= in_word.win_low)
                 && (hb_last <= {1'b0, in_word.win_last})
                 && (in_word.hot != lapsel_pkg::ALL_ONES)
                 && (((in_word.adr ^ in_word.hot) & low_mask) == '0);
      word_in       = in_word;
      word_in.alive = grow;
      word_in.order = grow ? in_word.order + lapsel_pkg::ORDER_W'(1) : in_word.order;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
